/* hdl/ipvh_pkg.sv */
// ============================================================================
// ipvh_pkg: shared types and constants for the IPv4 universal hash
// Field widths, register indexes and the data carried between pipeline cells.
// ============================================================================
package ipvh_pkg;

    // Fixed field and register widths
    localparam int ADDRESS_BITS = 32;
    localparam int CHUNK_W      = 4;
    localparam int PRIME_W      = 13;
    localparam int GROUP_W      = 64;
    localparam int COEF_BITS    = 16;
    localparam int COEF_COUNT   = 8;
    localparam int SLICE_W      = 12;
    localparam int PROD_W       = SLICE_W + COEF_BITS;
    // Largest weighted sum (three 12-bit chunks at most) stays below 2^30
    localparam int SUM_W        = 30;
    localparam int OUT_TDATA_W  = 16;

    // Chunk width limits
    localparam logic [CHUNK_W-1:0] CHUNK_MIN = 4'd4;
    localparam logic [CHUNK_W-1:0] CHUNK_MAX = 4'd12;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHUNK_BITS = 2'd0;
    localparam logic [1:0] CFG_PRIME      = 2'd1;
    localparam logic [1:0] CFG_COEF_LOW   = 2'd2;
    localparam logic [1:0] CFG_COEF_HIGH  = 2'd3;

    // Controls broadcast to every multiply-accumulate cell
    typedef struct packed {
        logic               enable;
        logic [SLICE_W-1:0] chunk_mask;
        logic [CHUNK_W-1:0] chunk_shift;
    } mac_ctrl_t;

    // Data handed from one multiply-accumulate cell to the next
    typedef struct packed {
        logic [ADDRESS_BITS-1:0] addr;
        logic [SUM_W-1:0]        sum;
    } mac_data_t;

    // Data handed from one reduction cell to the next
    typedef struct packed {
        logic [PRIME_W-1:0] rem;
        logic [SUM_W-1:0]   bits;
    } mod_data_t;

endpackage

/* hdl/ipvh_mac_cell.sv */
// ============================================================================
// ipvh_mac_cell: one chunk of the weighted sum
// Takes the low chunk of the shifted address, multiplies it by its coefficient,
// adds it to the running sum and hands the address on shifted by one chunk.
// ============================================================================
module ipvh_mac_cell
    import ipvh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mac_ctrl_t            ctrl,
    input  logic [COEF_BITS-1:0] coef,
    input  logic                 valid_in,
    input  mac_data_t            data_in,
    output logic                 valid_out,
    output mac_data_t            data_out
);

    logic              valid_reg;
    mac_data_t         data_reg;
    mac_data_t         data_next;
    logic [SLICE_W-1:0] chunk;
    logic [PROD_W-1:0]  product;

    // Multiply the low chunk and accumulate
    always_comb
    begin
        chunk          = data_in.addr[SLICE_W-1:0] & ctrl.chunk_mask;
        product        = PROD_W'(chunk) * PROD_W'(coef);
        data_next.sum  = data_in.sum + SUM_W'(product);
        data_next.addr = data_in.addr >> ctrl.chunk_shift;
    end

    // Advance the valid flag whenever the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.enable)
        begin
            valid_reg <= valid_in;
        end
    end

    // Capture the payload only for a live request
    always_ff @(posedge clk)
    begin
        if (ctrl.enable && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* hdl/ipvh_mod_cell.sv */
// ============================================================================
// ipvh_mod_cell: one bit of the modulo reduction
// Shifts the next sum bit into the remainder and subtracts the modulus once
// when the remainder reaches it.
// ============================================================================
module ipvh_mod_cell
    import ipvh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic [PRIME_W-1:0] prime,
    input  logic               valid_in,
    input  mod_data_t          data_in,
    output logic               valid_out,
    output mod_data_t          data_out
);

    logic               valid_reg;
    mod_data_t          data_reg;
    mod_data_t          data_next;
    logic [PRIME_W:0]   partial;
    logic [PRIME_W:0]   diff;

    // Bring in one bit and conditionally subtract the modulus
    always_comb
    begin
        partial        = {data_in.rem, data_in.bits[SUM_W-1]};
        diff           = partial - {1'b0, prime};
        data_next.rem  = (partial >= {1'b0, prime}) ? diff[PRIME_W-1:0]
                                                    : partial[PRIME_W-1:0];
        data_next.bits = {data_in.bits[SUM_W-2:0], 1'b0};
    end

    // Advance the valid flag whenever the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    // Capture the payload only for a live request
    always_ff @(posedge clk)
    begin
        if (enable && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* hdl/ipvh_skid.sv */
// ============================================================================
// ipvh_skid: output register with skid stage
// Holds the finished result for the downstream side; a second entry catches
// the request already leaving the pipeline when the output stalls.
// ============================================================================
module ipvh_skid
    import ipvh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PRIME_W-1:0] in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PRIME_W-1:0] out_data
);

    logic               out_valid_reg;
    logic [PRIME_W-1:0] out_data_reg;
    logic               skid_valid_reg;
    logic [PRIME_W-1:0] skid_data_reg;
    logic               in_take;
    logic               out_free;

    assign in_ready = !skid_valid_reg;
    assign in_take  = in_valid && !skid_valid_reg;
    assign out_free = out_ready || !out_valid_reg;

    // Track occupancy of the output and skid entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_take;
            skid_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move payloads: skid drains first, else the incoming request
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_take)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (in_take)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/ipv4_universal_hash.sv */
// Path: an accepted address passes through the multiply-accumulate cells, the
// reduction cells and the output register with skid stage before its result appears.
// Throughput: one address per cycle unless stalled; a row of multiply-accumulate
// cells feeds a row of 30 one-bit reduction cells, all advancing together.
// Reset: configuration returns to 8-bit chunks, modulus 257, zero coefficients;
// the pipeline and output buffer empty at once, no clearing pass.
// ============================================================================
// ipv4_universal_hash: Carter-Wegman hash of an IPv4 address
// Splits the address into chunks, sums chunk times coefficient over a chain of
// cells and reduces the sum modulo a programmable prime, one bit per cell.
// ============================================================================
module ipv4_universal_hash
    import ipvh_pkg::*;
#(
    parameter int MAX_CHUNKS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Address stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ADDRESS_BITS-1:0] s_tdata,   // [31:0] ip_address
    // Hash stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // [12:0] bucket_index, [15:13] zero
    // Configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [GROUP_W-1:0]      cfg_data
);

    logic [CHUNK_W-1:0] chunk_bits_reg;
    logic [PRIME_W-1:0] prime_reg;
    logic [GROUP_W-1:0] coef_low_reg;
    logic [GROUP_W-1:0] coef_high_reg;

    logic [CHUNK_W-1:0]             chunk_eff;
    logic [2*GROUP_W-1:0]           coef_all;
    logic                           pipe_enable;
    mac_ctrl_t                      mac_ctrl;

    logic                           mac_valid [0:MAX_CHUNKS];
    mac_data_t                      mac_data  [0:MAX_CHUNKS];
    logic                           mod_valid [0:SUM_W];
    mod_data_t                      mod_data  [0:SUM_W];

    logic [PRIME_W-1:0]             bucket;
    logic [PRIME_W-1:0]             out_bucket;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bits_reg <= 4'd8;
            prime_reg      <= 13'd257;
            coef_low_reg   <= '0;
            coef_high_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHUNK_BITS: chunk_bits_reg <= cfg_data[CHUNK_W-1:0];
                CFG_PRIME:      prime_reg      <= cfg_data[PRIME_W-1:0];
                CFG_COEF_LOW:   coef_low_reg   <= cfg_data;
                CFG_COEF_HIGH:  coef_high_reg  <= cfg_data;
                default:        chunk_bits_reg <= chunk_bits_reg;
            endcase
        end
    end

    // Clamp the chunk width and build the chunk mask
    always_comb
    begin
        if (chunk_bits_reg < CHUNK_MIN)
        begin
            chunk_eff = CHUNK_MIN;
        end
        else if (chunk_bits_reg > CHUNK_MAX)
        begin
            chunk_eff = CHUNK_MAX;
        end
        else
        begin
            chunk_eff = chunk_bits_reg;
        end
    end

    assign coef_all             = {coef_high_reg, coef_low_reg};
    assign mac_ctrl.enable      = pipe_enable;
    assign mac_ctrl.chunk_mask  = ~({SLICE_W{1'b1}} << chunk_eff);
    assign mac_ctrl.chunk_shift = chunk_eff;

    assign s_tready = pipe_enable;

    // Feed the first multiply-accumulate cell
    assign mac_valid[0]     = s_tvalid;
    assign mac_data[0].addr = s_tdata;
    assign mac_data[0].sum  = '0;

    // Chain of multiply-accumulate cells, one per chunk
    for (genvar i = 0; i < MAX_CHUNKS; i++)
    begin : g_mac
        ipvh_mac_cell u_mac (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (mac_ctrl),
            .coef      (coef_all[i*COEF_BITS +: COEF_BITS]),
            .valid_in  (mac_valid[i]),
            .data_in   (mac_data[i]),
            .valid_out (mac_valid[i+1]),
            .data_out  (mac_data[i+1])
        );
    end

    // Start the reduction with an empty remainder
    assign mod_valid[0]     = mac_valid[MAX_CHUNKS];
    assign mod_data[0].rem  = '0;
    assign mod_data[0].bits = mac_data[MAX_CHUNKS].sum;

    // Chain of reduction cells, one per sum bit
    for (genvar j = 0; j < SUM_W; j++)
    begin : g_mod
        ipvh_mod_cell u_mod (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (pipe_enable),
            .prime     (prime_reg),
            .valid_in  (mod_valid[j]),
            .data_in   (mod_data[j]),
            .valid_out (mod_valid[j+1]),
            .data_out  (mod_data[j+1])
        );
    end

    // Force a zero hash when the modulus is zero
    assign bucket = (prime_reg == '0) ? '0 : mod_data[SUM_W].rem;

    // Output register with skid stage
    ipvh_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mod_valid[SUM_W]),
        .in_ready  (pipe_enable),
        .in_data   (bucket),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_bucket)
    );

    assign m_tdata = {{(OUT_TDATA_W-PRIME_W){1'b0}}, out_bucket};

`ifndef SYNTH
    // Zero modulus always yields a zero hash
    a_zero_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && prime_reg == '0) |-> (m_tdata == '0))
        else $error("hash not zero with zero modulus");

    // A nonzero modulus bounds the hash
    a_below_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && prime_reg != '0) |-> (m_tdata[PRIME_W-1:0] < prime_reg))
        else $error("hash not below modulus");

    // Input stalls only while a result is held at the output
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("pipeline stalled with empty output");
`endif

endmodule
